// ===== src/dlle_pkg.sv =====
// shared constants and types for the doubly linked list engine
package dlle_pkg;
   localparam int Capacity = 64;
   localparam int IdxW = 7;
   localparam int SlotW = 6;
   localparam int ValW = 32;
   localparam int SumW = 40;

   localparam logic [IdxW-1:0] NIL = 7'd64;

   localparam logic [2:0] OP_INS_HEAD = 3'd0;
   localparam logic [2:0] OP_INS_TAIL = 3'd1;
   localparam logic [2:0] OP_INS_BEFORE = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_AVERAGE = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;
endpackage

// ===== src/dlle_divider.sv =====
// restoring divider for the average: magnitude of sum by entry count
module dlle_divider (
   input  logic clock,
   input  logic reset,
   input  dlle_pkg::div_ctl_type ctl,
   input  logic [dlle_pkg::SumW-1:0] dividend_mag,
   input  logic [dlle_pkg::IdxW-1:0] divisor,
   output logic done,
   output logic [dlle_pkg::ValW-1:0] quotient
);
   logic [dlle_pkg::SumW-1:0] q_ff, q_in;
   logic [dlle_pkg::IdxW:0] r_ff, r_in;
   logic [dlle_pkg::IdxW-1:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [dlle_pkg::IdxW:0] trial;
   logic [dlle_pkg::SumW-1:0] qs;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      trial = {r_ff[dlle_pkg::IdxW-1:0], q_ff[dlle_pkg::SumW-1]};
      if (ctl.start) begin
         q_in = dividend_mag; r_in = '0; d_in = divisor;
         cnt_in = 6'(dlle_pkg::SumW); busy_in = 1'b1; neg_in = ctl.neg;
      end else if (busy_ff) begin
         q_in = {q_ff[dlle_pkg::SumW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign qs = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign done = done_ff;
   assign quotient = qs[dlle_pkg::ValW-1:0];
endmodule

// ===== src/doubly_linked_list_engine_unit.sv =====
// top level of the doubly linked list engine
// unused opcode or early status goes straight to the response; insert head/tail adds one node
// insert before and delete walk from the head to the first match; a miss walks the whole list
// average walks every node, then divides the sum by the entry count for the result
// one request at a time; the result register frees the core while a response waits
// synchronous active-high reset empties the list; node memory needs no clearing
module doubly_linked_list_engine_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_opcode,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_reference,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_average,
   output logic [6:0] rsp_entry_total
);
   localparam int IW = dlle_pkg::IdxW;
   localparam int SW = dlle_pkg::SlotW;
   localparam int NW = dlle_pkg::ValW + 2 * IW;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ALLOC = 4'd1;
   localparam logic [3:0] S_RD = 4'd2;
   localparam logic [3:0] S_CHK = 4'd3;
   localparam logic [3:0] S_LINK1 = 4'd4;
   localparam logic [3:0] S_LINK2 = 4'd5;
   localparam logic [3:0] S_DIVW = 4'd6;
   localparam logic [3:0] S_RESP = 4'd7;
   localparam logic [3:0] S_DRD = 4'd8;
   localparam logic [3:0] S_DCHK = 4'd9;

   // node memory: value, next, prev packed in one word
   logic [NW-1:0] mem [dlle_pkg::Capacity];
   logic [NW-1:0] rd_q;
   logic we;
   logic [SW-1:0] waddr, raddr;
   logic [NW-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_q <= mem[raddr];
   end

   logic [31:0] q_val;
   logic [IW-1:0] q_next, q_prev;
   assign q_val = rd_q[NW-1 -: 32];
   assign q_next = rd_q[2*IW-1 -: IW];
   assign q_prev = rd_q[IW-1:0];

   logic [3:0] st_ff, st_in;
   logic [dlle_pkg::Capacity-1:0] free_ff, free_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic [IW-1:0] cur_ff, cur_in, tgt_ff, tgt_in, nslot_ff, nslot_in;
   logic [IW-1:0] tprev_ff, tprev_in, tnext_ff, tnext_in, walked_ff, walked_in;
   logic [2:0] op_ff, op_in;
   logic [31:0] val_ff, val_in, ref_ff, ref_in;
   logic signed [dlle_pkg::SumW-1:0] sum_ff, sum_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] avg_ff, avg_in;
   logic rv_ff, rv_in;
   // result register, loaded when a request finishes
   logic [1:0] out_status_ff, out_status_in;
   logic [31:0] out_avg_ff, out_avg_in;
   logic [IW-1:0] out_total_ff, out_total_in;
   logic [IW-1:0] lowfree;
   dlle_pkg::div_ctl_type dctl;
   logic ddone;
   logic [31:0] dq;
   logic [dlle_pkg::SumW-1:0] dmag;

   // lowest free slot by priority scan
   always_comb begin
      lowfree = dlle_pkg::NIL;
      for (int i = dlle_pkg::Capacity - 1; i >= 0; i--)
         if (free_ff[i]) lowfree = IW'(i);
   end

   // divider loads the finished sum, last node included
   assign dmag = sum_in[dlle_pkg::SumW-1] ? dlle_pkg::SumW'(-sum_in) : sum_in;

   dlle_divider u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend_mag(dmag),
      .divisor(cnt_ff), .done(ddone), .quotient(dq)
   );

   assign req_ready = (st_ff == S_IDLE);

   always_comb begin
      st_in = st_ff; free_in = free_ff; head_in = head_ff; tail_in = tail_ff;
      cnt_in = cnt_ff; cur_in = cur_ff; tgt_in = tgt_ff; nslot_in = nslot_ff;
      tprev_in = tprev_ff; tnext_in = tnext_ff; walked_in = walked_ff;
      op_in = op_ff; val_in = val_ff; ref_in = ref_ff; sum_in = sum_ff;
      status_in = status_ff; avg_in = avg_ff; rv_in = rv_ff;
      out_status_in = out_status_ff; out_avg_in = out_avg_ff; out_total_in = out_total_ff;
      we = 1'b0; waddr = '0; wdata = '0; raddr = cur_ff[SW-1:0];
      dctl = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_opcode; val_in = req_value; ref_in = req_reference;
               status_in = dlle_pkg::ST_OK; avg_in = '0; sum_in = '0;
               cur_in = head_ff; walked_in = '0;
               priority if (req_opcode == dlle_pkg::OP_INS_HEAD
                            || req_opcode == dlle_pkg::OP_INS_TAIL) begin
                  if (cnt_ff == dlle_pkg::NIL) begin
                     status_in = dlle_pkg::ST_FULL; st_in = S_RESP;
                  end else st_in = S_ALLOC;
               end else if (req_opcode == dlle_pkg::OP_INS_BEFORE) begin
                  if (cnt_ff == '0) begin
                     status_in = dlle_pkg::ST_EMPTY; st_in = S_RESP;
                  end else if (cnt_ff == dlle_pkg::NIL) begin
                     status_in = dlle_pkg::ST_FULL; st_in = S_RESP;
                  end else st_in = S_RD;
               end else if (req_opcode == dlle_pkg::OP_DELETE
                            || req_opcode == dlle_pkg::OP_AVERAGE) begin
                  if (cnt_ff == '0) begin
                     status_in = dlle_pkg::ST_EMPTY; st_in = S_RESP;
                  end else st_in = S_RD;
               end else begin
                  st_in = S_RESP;
               end
            end
         end
         S_ALLOC: begin
            // write new node; unless the list was empty, fix neighbor link via read-modify-write
            nslot_in = lowfree;
            free_in[lowfree[SW-1:0]] = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            we = 1'b1; waddr = lowfree[SW-1:0];
            if (head_ff == dlle_pkg::NIL) begin
               wdata = {val_ff, dlle_pkg::NIL, dlle_pkg::NIL};
               head_in = lowfree; tail_in = lowfree; st_in = S_RESP;
            end else if (op_ff == dlle_pkg::OP_INS_HEAD) begin
               wdata = {val_ff, head_ff, dlle_pkg::NIL};
               head_in = lowfree; tgt_in = head_ff;
               raddr = head_ff[SW-1:0]; st_in = S_LINK1;
            end else begin
               wdata = {val_ff, dlle_pkg::NIL, tail_ff};
               tail_in = lowfree; tgt_in = tail_ff;
               raddr = tail_ff[SW-1:0]; st_in = S_LINK1;
            end
         end
         S_LINK1: begin
            we = 1'b1; waddr = tgt_ff[SW-1:0];
            if (op_ff == dlle_pkg::OP_INS_HEAD)
               wdata = {q_val, q_next, nslot_ff};
            else
               wdata = {q_val, nslot_ff, q_prev};
            st_in = S_RESP;
         end
         S_RD: begin
            raddr = cur_ff[SW-1:0];
            st_in = S_CHK;
         end
         S_CHK: begin
            walked_in = walked_ff + 1'b1;
            if (op_ff == dlle_pkg::OP_AVERAGE) begin
               sum_in = sum_ff + dlle_pkg::SumW'(signed'(q_val));
               if (q_next == dlle_pkg::NIL || walked_ff + 1'b1 == dlle_pkg::NIL) begin
                  dctl.start = 1'b1;
                  dctl.neg = sum_in[dlle_pkg::SumW-1];
                  st_in = S_DIVW;
               end else begin
                  cur_in = q_next; st_in = S_RD;
               end
            end else if (q_val == ref_ff) begin
               tgt_in = cur_ff; tprev_in = q_prev; tnext_in = q_next;
               if (op_ff == dlle_pkg::OP_INS_BEFORE) begin
                  // new node takes target's place before it
                  nslot_in = lowfree;
                  free_in[lowfree[SW-1:0]] = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
                  we = 1'b1; waddr = lowfree[SW-1:0];
                  wdata = {val_ff, cur_ff, q_prev};
                  st_in = S_LINK2;
                  if (q_prev == dlle_pkg::NIL) head_in = lowfree;
               end else begin
                  free_in[cur_ff[SW-1:0]] = 1'b1;
                  cnt_in = cnt_ff - 1'b1;
                  if (q_prev == dlle_pkg::NIL) head_in = q_next;
                  if (q_next == dlle_pkg::NIL) tail_in = q_prev;
                  st_in = S_DRD;
               end
            end else if (q_next == dlle_pkg::NIL || walked_ff + 1'b1 == dlle_pkg::NIL) begin
               status_in = dlle_pkg::ST_NOTFOUND; st_in = S_RESP;
            end else begin
               cur_in = q_next; st_in = S_RD;
            end
         end
         S_LINK2: begin
            // target prev -> new node; then read old prev to relink its next
            raddr = tprev_ff[SW-1:0];
            we = 1'b1; waddr = tgt_ff[SW-1:0];
            wdata = {ref_ff, tnext_ff, nslot_ff};
            if (tprev_ff == dlle_pkg::NIL) st_in = S_RESP;
            else begin
               op_in = dlle_pkg::OP_INS_TAIL; tgt_in = tprev_ff; st_in = S_LINK1;
            end
         end
         S_DRD: begin
            // relink prev.next, then next.prev
            if (tprev_ff != dlle_pkg::NIL) begin
               raddr = tprev_ff[SW-1:0]; st_in = S_DCHK;
            end else if (tnext_ff != dlle_pkg::NIL) begin
               // deleting the head: the next node's new prev is nil
               raddr = tnext_ff[SW-1:0]; tprev_in = tnext_ff; cur_in = dlle_pkg::NIL;
               tnext_in = dlle_pkg::NIL; tgt_in = dlle_pkg::NIL; st_in = S_DCHK;
            end else st_in = S_RESP;
         end
         S_DCHK: begin
            we = 1'b1; waddr = tprev_ff[SW-1:0];
            if (tgt_ff == dlle_pkg::NIL) begin
               // fixing next node's prev; tgt holds nothing, prev saved in cur
               wdata = {q_val, q_next, cur_ff};
               st_in = S_RESP;
            end else begin
               wdata = {q_val, tnext_ff, q_prev};
               if (tnext_ff != dlle_pkg::NIL) begin
                  raddr = tnext_ff[SW-1:0];
                  cur_in = tprev_ff; tprev_in = tnext_ff; tgt_in = dlle_pkg::NIL;
                  st_in = S_DCHK;
                  // read issued now returns next cycle
               end else st_in = S_RESP;
            end
         end
         S_DIVW: begin
            if (ddone) begin
               avg_in = dq; st_in = S_RESP;
            end
         end
         S_RESP: begin
            // wait only while an older response is still held
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1; st_in = S_IDLE;
               out_status_in = status_ff; out_avg_in = avg_ff; out_total_in = cnt_ff;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; val_ff <= val_in; ref_ff <= ref_in; sum_ff <= sum_in;
      tgt_ff <= tgt_in; nslot_ff <= nslot_in; tprev_ff <= tprev_in;
      tnext_ff <= tnext_in; walked_ff <= walked_in; avg_ff <= avg_in;
      status_ff <= status_in; cur_ff <= cur_in;
      out_status_ff <= out_status_in; out_avg_ff <= out_avg_in;
      out_total_ff <= out_total_in;
      if (reset) begin
         st_ff <= S_IDLE; free_ff <= '1; head_ff <= dlle_pkg::NIL;
         tail_ff <= dlle_pkg::NIL; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; free_ff <= free_in; head_ff <= head_in;
         tail_ff <= tail_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = out_status_ff;
   assign rsp_average = out_avg_ff;
   assign rsp_entry_total = out_total_ff;
endmodule
